>>> design/tcsg_pkg.sv
`default_nettype none

package tcsg_pkg;

    // register file
    localparam int REG_FILE_DEPTH = 16;
    localparam int REG_ADDR_W     = $clog2(REG_FILE_DEPTH);
    localparam int REGISTER_COUNT = 16;

    // register numbers with a fixed meaning
    localparam logic [7:0] REG_NOISE_PERIOD = 8'd6;
    localparam logic [7:0] REG_MIXER        = 8'd7;
    localparam logic [7:0] REG_VOLUME_A     = 8'd8;
    localparam logic [7:0] REG_ENV_FINE     = 8'd11;
    localparam logic [7:0] REG_ENV_COARSE   = 8'd12;
    localparam logic [7:0] REG_ENV_SHAPE    = 8'd13;
    localparam logic [7:0] REG_JOYSTICK     = 8'd14;

    // bus ports
    localparam logic [1:0] PORT_DATA_READ  = 2'd0;
    localparam logic [1:0] PORT_SELECT     = 2'd1;
    localparam logic [1:0] PORT_DATA_WRITE = 2'd2;

    // envelope shape bits
    localparam int SHAPE_HOLD      = 0;
    localparam int SHAPE_ALTERNATE = 1;
    localparam int SHAPE_ATTACK    = 2;
    localparam int SHAPE_CONTINUE  = 3;

    localparam int NUM_CHANNELS = 3;
    localparam int LEVEL_W      = 14;

    typedef enum logic [1:0] {
        OP_READ     = 2'd0,
        OP_WRITE    = 2'd1,
        OP_TICK     = 2'd2,
        OP_JOYSTICK = 2'd3
    } t_opcode;

    typedef struct packed {
        logic step;
        logic restart;
        logic restart_rising;
    } t_env_ctrl;

    // logarithmic dac levels
    function automatic logic [LEVEL_W-1:0] level_of(input logic [3:0] vol);
        logic [LEVEL_W-1:0] lv;
        unique case (vol)
            4'd0:  lv = 14'd0;
            4'd1:  lv = 14'd139;
            4'd2:  lv = 14'd202;
            4'd3:  lv = 14'd295;
            4'd4:  lv = 14'd436;
            4'd5:  lv = 14'd645;
            4'd6:  lv = 14'd899;
            4'd7:  lv = 14'd1470;
            4'd8:  lv = 14'd1732;
            4'd9:  lv = 14'd2784;
            4'd10: lv = 14'd3889;
            4'd11: lv = 14'd4882;
            4'd12: lv = 14'd6161;
            4'd13: lv = 14'd7736;
            4'd14: lv = 14'd9199;
            default: lv = 14'd10922;
        endcase
        return lv;
    endfunction

endpackage

`default_nettype wire

>>> design/three_channel_sound_generator.sv
`default_nettype none

// Three-channel sound generator behind a register-select / data bus port.
// Each input item is a bus read, a bus write, one master clock tick or a
// joystick byte update, and every item gives exactly one result item:
// read_data (0xFF unless it is a mapped read) and mixed_level (the signed
// mix of the three channels on a tick, 0 otherwise). An item is latched in
// an input register, and all its work (register file access, tone, noise
// and envelope counters, mixing through the level table) is combinational
// from the input register into the result register, and an item moves on
// into the result register unless the result side stalls; a new item is
// accepted every cycle as long as the result side keeps taking them.
// board_present may only be written while
// no item is in flight; with it at 0 reads give 0xFF, bus writes are
// dropped and ticks give level 0 without advancing the generators.

module three_channel_sound_generator import tcsg_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // item input channel
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [1:0]        i_opcode,
    input  wire logic [1:0]        i_port,
    input  wire logic [7:0]        i_data_byte,
    // result channel
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [7:0]             o_read_data,
    output logic signed [15:0]     o_mixed_level,
    // configuration (board_present)
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic              i_cfg_data
);

    // input register
    logic        r_in_valid;
    t_opcode     r_in_opcode;
    logic [1:0]  r_in_port;
    logic [7:0]  r_in_byte;

    // result register
    logic               r_out_valid;
    logic [7:0]         r_read_data, n_read_data;
    logic signed [15:0] r_mixed_level, n_mixed_level;

    // block state
    logic       r_board_present;
    logic [7:0] r_rf [REG_FILE_DEPTH];
    logic [7:0] r_sel;
    logic [7:0] r_joystick;

    logic adv;
    logic in_accept;
    logic sel_in_range;
    logic do_tick;
    logic do_select;
    logic do_data_write;

    logic [NUM_CHANNELS-1:0] square;
    logic                    noise;
    logic [3:0]              env_amp;
    logic [7:0]              volume [NUM_CHANNELS];
    logic signed [15:0]      mix_level;
    t_env_ctrl               env_ctrl;

    // the latched item moves on whenever the result register is free or emptying
    assign adv       = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && !adv;
    assign in_accept = i_valid && !o_stall;
    assign o_valid   = r_out_valid;
    assign o_read_data   = r_read_data;
    assign o_mixed_level = r_mixed_level;
    assign o_cfg_ready   = 1'b1;

    assign sel_in_range  = (r_sel < 8'(REGISTER_COUNT));
    assign do_tick       = adv && (r_in_opcode == OP_TICK) && r_board_present;
    assign do_select     = adv && (r_in_opcode == OP_WRITE) && r_board_present
                           && (r_in_port == PORT_SELECT);
    assign do_data_write = adv && (r_in_opcode == OP_WRITE) && r_board_present
                           && (r_in_port == PORT_DATA_WRITE) && sel_in_range;

    // writing the shape register restarts the envelope
    always_comb begin
        env_ctrl.step           = do_tick;
        env_ctrl.restart        = do_data_write && (r_sel == REG_ENV_SHAPE);
        env_ctrl.restart_rising = r_in_byte[SHAPE_ATTACK];
    end

    // tone generators, one per channel
    for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_tone
        tcsg_tone u_tone (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_step   (do_tick),
            .i_period ({r_rf[2*c+1][3:0], r_rf[2*c]}),
            .o_square (square[c])
        );
        assign volume[c] = r_rf[REG_VOLUME_A[REG_ADDR_W-1:0] + REG_ADDR_W'(c)];
    end

    tcsg_noise u_noise (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (do_tick),
        .i_period (r_rf[REG_NOISE_PERIOD[REG_ADDR_W-1:0]][4:0]),
        .o_noise  (noise)
    );

    tcsg_env u_env (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (env_ctrl),
        .i_period ({r_rf[REG_ENV_COARSE[REG_ADDR_W-1:0]],
                    r_rf[REG_ENV_FINE[REG_ADDR_W-1:0]]}),
        .i_shape  (r_rf[REG_ENV_SHAPE[REG_ADDR_W-1:0]][3:0]),
        .o_level  (env_amp)
    );

    tcsg_mix u_mix (
        .i_mixer     (r_rf[REG_MIXER[REG_ADDR_W-1:0]]),
        .i_volume    (volume),
        .i_square    (square),
        .i_noise     (noise),
        .i_env_amp   (env_amp),
        .o_level     (mix_level)
    );

    // result of the latched item
    always_comb begin
        n_read_data   = 8'hFF;
        n_mixed_level = '0;
        case (r_in_opcode)
            OP_READ: begin
                if (r_board_present && (r_in_port == PORT_DATA_READ)) begin
                    // the joystick register reads the port byte, not the file
                    if (r_sel == REG_JOYSTICK) begin
                        n_read_data = r_joystick;
                    end else if (sel_in_range) begin
                        n_read_data = r_rf[r_sel[REG_ADDR_W-1:0]];
                    end
                end
            end
            OP_TICK: begin
                if (r_board_present) begin
                    n_mixed_level = mix_level;
                end
            end
            default: begin
                n_read_data   = 8'hFF;
                n_mixed_level = '0;
            end
        endcase
    end

    // control and pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_board_present <= 1'b1;
            r_sel           <= '0;
            r_joystick      <= 8'hFF;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_board_present <= i_cfg_data;
            end
            if (do_select) begin
                r_sel <= r_in_byte;
            end
            // joystick byte is taken even with the board absent
            if (adv && (r_in_opcode == OP_JOYSTICK)) begin
                r_joystick <= r_in_byte;
            end
        end
    end

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REG_FILE_DEPTH; i++) begin
                r_rf[i] <= '0;
            end
        end else if (do_data_write) begin
            r_rf[r_sel[REG_ADDR_W-1:0]] <= r_in_byte;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_opcode <= t_opcode'(i_opcode);
            r_in_port   <= i_port;
            r_in_byte   <= i_data_byte;
        end
        if (adv) begin
            r_read_data   <= n_read_data;
            r_mixed_level <= n_mixed_level;
        end
    end

    // an item that is not a tick never produces a level
    a_level_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && (r_in_opcode != OP_TICK) |=> o_mixed_level == 16'sd0)
        else $error("level on a non-tick item");

    // an item that is not a read returns the idle bus byte
    a_idle_read_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && (r_in_opcode != OP_READ) |=> o_read_data == 8'hFF)
        else $error("read data on a non-read item");

    // with the board absent a tick is silent
    a_absent_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && !r_board_present |=> o_mixed_level == 16'sd0)
        else $error("level while board absent");

    // a latched item that cannot move on is kept
    a_item_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid)
        else $error("latched item dropped");

endmodule

`default_nettype wire

>>> design/tcsg_tone.sv
`default_nettype none

module tcsg_tone import tcsg_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_step,
    input  wire logic [11:0] i_period,
    output logic             o_square
);

    logic [14:0] r_div, n_div;
    logic        r_square, n_square;
    logic [14:0] inc;
    logic [14:0] limit;
    logic        wrap;

    always_comb begin
        inc      = r_div + 15'd1;
        limit    = {((i_period == 12'd0) ? 12'd1 : i_period), 3'b000};
        wrap     = (inc >= limit);
        n_div    = wrap ? 15'd0 : inc;
        n_square = r_square ^ wrap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div    <= '0;
            r_square <= 1'b0;
        end else if (i_step) begin
            r_div    <= n_div;
            r_square <= n_square;
        end
    end

    // square level after this tick
    assign o_square = n_square;

endmodule

`default_nettype wire

>>> design/tcsg_noise.sv
`default_nettype none

module tcsg_noise import tcsg_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [4:0] i_period,
    output logic            o_noise
);

    logic [8:0]  r_div, n_div;
    logic [16:0] r_shift, n_shift;
    logic [8:0]  inc;
    logic [8:0]  limit;
    logic        wrap;

    always_comb begin
        inc     = r_div + 9'd1;
        limit   = {((i_period == 5'd0) ? 5'd1 : i_period), 4'b0000};
        wrap    = (inc >= limit);
        n_div   = wrap ? 9'd0 : inc;
        n_shift = wrap ? {r_shift[0] ^ r_shift[3], r_shift[16:1]} : r_shift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div   <= '0;
            r_shift <= 17'd1;
        end else if (i_step) begin
            r_div   <= n_div;
            r_shift <= n_shift;
        end
    end

    assign o_noise = n_shift[0];

endmodule

`default_nettype wire

>>> design/tcsg_env.sv
`default_nettype none

module tcsg_env import tcsg_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_env_ctrl   i_ctrl,
    input  wire logic [15:0] i_period,
    input  wire logic [3:0]  i_shape,
    output logic [3:0]       o_level
);

    logic [16:0] r_div, n_div;
    logic [4:0]  r_pos, n_pos;
    logic        r_rising, n_rising;
    logic        r_frozen, n_frozen;
    logic [16:0] inc;
    logic [16:0] limit;

    always_comb begin
        inc      = r_div + 17'd1;
        limit    = {((i_period == 16'd0) ? 16'd1 : i_period), 1'b0};
        n_div    = r_div;
        n_pos    = r_pos;
        n_rising = r_rising;
        n_frozen = r_frozen;
        if (!r_frozen) begin
            if (inc >= limit) begin
                n_div = '0;
                if (r_pos == 5'd31) begin
                    // end of a ramp: the shape decides what comes next
                    if (!i_shape[SHAPE_CONTINUE]) begin
                        n_pos    = r_rising ? 5'd0 : 5'd31;
                        n_frozen = 1'b1;
                    end else if (i_shape[SHAPE_HOLD]) begin
                        n_rising = r_rising ^ i_shape[SHAPE_ALTERNATE];
                        n_pos    = 5'd31;
                        n_frozen = 1'b1;
                    end else begin
                        n_rising = r_rising ^ i_shape[SHAPE_ALTERNATE];
                        n_pos    = 5'd0;
                    end
                end else begin
                    n_pos = r_pos + 5'd1;
                end
            end else begin
                n_div = inc;
            end
        end
        // (31 - pos) / 2 is the upper four bits of ~pos
        o_level = n_rising ? n_pos[4:1] : ~n_pos[4:1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div    <= '0;
            r_pos    <= '0;
            r_rising <= 1'b0;
            r_frozen <= 1'b0;
        end else if (i_ctrl.restart) begin
            r_div    <= '0;
            r_pos    <= '0;
            r_rising <= i_ctrl.restart_rising;
            r_frozen <= 1'b0;
        end else if (i_ctrl.step) begin
            r_div    <= n_div;
            r_pos    <= n_pos;
            r_rising <= n_rising;
            r_frozen <= n_frozen;
        end
    end

endmodule

`default_nettype wire

>>> design/tcsg_mix.sv
`default_nettype none

module tcsg_mix import tcsg_pkg::*; (
    input  wire logic [7:0]              i_mixer,
    input  wire logic [7:0]              i_volume [NUM_CHANNELS],
    input  wire logic [NUM_CHANNELS-1:0] i_square,
    input  wire logic                    i_noise,
    input  wire logic [3:0]              i_env_amp,
    output logic signed [15:0]           o_level
);

    logic [LEVEL_W-1:0] ch_level [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] ch_on;
    logic [NUM_CHANNELS-1:0] ch_high;
    logic [15:0] sum;
    logic [15:0] scale;
    logic signed [17:0] diff;

    always_comb begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            // mixer bits are active low
            ch_on[c]    = !(i_mixer[c] && i_mixer[c+NUM_CHANNELS]);
            ch_high[c]  = (i_mixer[c] || i_square[c])
                          && (i_mixer[c+NUM_CHANNELS] || i_noise);
            ch_level[c] = level_of(i_volume[c][4] ? i_env_amp : i_volume[c][3:0]);
        end
        sum   = '0;
        scale = '0;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (ch_on[c]) begin
                scale = scale + 16'(ch_level[c]);
                if (ch_high[c]) begin
                    sum = sum + 16'(ch_level[c]);
                end
            end
        end
        diff    = signed'({1'b0, sum, 1'b0}) - signed'({2'b00, scale});
        o_level = diff[15:0];
    end

endmodule

`default_nettype wire
